// ----- src/wfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg
// Types and constants shared by the websocket frame decoder modules.
// ----------------------------------------------------------------------------
package wfd_pkg;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_EXT    = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_e;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam int unsigned EXT16_BYTES   = 2;
  localparam int unsigned EXT64_BYTES   = 8;
  localparam int unsigned KEY_BYTES     = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- src/wfd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_in_if
// Received byte channel: valid/ready handshake with one stream byte per item.
// ----------------------------------------------------------------------------
interface wfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/wfd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_out_if
// Decoded result channel: valid/ready handshake with one payload item.
// ----------------------------------------------------------------------------
interface wfd_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [3:0] message_opcode;
  logic       frame_end;
  logic       message_end;

  modport source (output valid, output data_valid, output data_byte,
                  output message_opcode, output frame_end, output message_end,
                  input ready);
  modport sink (input valid, input data_valid, input data_byte,
                input message_opcode, input frame_end, input message_end,
                output ready);
endinterface

// ----- src/wfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_front
// Frame header parser: tracks the phase of the frame, the length and the mask
// key, and queues one result item for each payload byte or zero-length frame end.
// ----------------------------------------------------------------------------
module wfd_front #(
  parameter int unsigned LEN_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 push_o,
  output wfd_pkg::queue_item_t item_o
);

  wfd_pkg::phase_e     phase_q, phase_d;
  logic [LEN_BITS-1:0] left_q, left_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [31:0]         key_q, key_d;
  logic                mask_q, mask_d;
  logic [1:0]          pos_q, pos_d;
  logic                fin_q, fin_d;
  logic [3:0]          opcode_q, opcode_d;
  logic                in_msg_q, in_msg_d;

  logic [LEN_BITS-1:0] left_dec;
  logic                left_last;
  logic [LEN_BITS-1:0] ext_len;
  logic [LEN_BITS-1:0] code_len;
  logic [7:0]          key_sel;

  assign left_last = (left_q[LEN_BITS-1:1] == '0);
  assign left_dec  = (left_q == '0) ? '0 : left_q - LEN_BITS'(1);
  assign ext_len   = {len_q[LEN_BITS-9:0], rx_byte_i};
  assign code_len  = LEN_BITS'(rx_byte_i[6:0]);

  always_comb begin
    case (pos_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    len_d    = len_q;
    key_d    = key_q;
    mask_d   = mask_q;
    pos_d    = pos_q;
    fin_d    = fin_q;
    opcode_d = opcode_q;
    in_msg_d = in_msg_q;
    push_o   = 1'b0;
    item_o   = '0;
    item_o.message_opcode = opcode_q;
    if (accept_i) begin
      case (phase_q)
        wfd_pkg::PH_LEN: begin
          mask_d = rx_byte_i[7];
          len_d  = '0;
          if (rx_byte_i[6:0] == wfd_pkg::LEN_CODE_EXT64) begin
            phase_d = wfd_pkg::PH_EXT;
            left_d  = LEN_BITS'(wfd_pkg::EXT64_BYTES);
          end else if (rx_byte_i[6:0] == wfd_pkg::LEN_CODE_EXT16) begin
            phase_d = wfd_pkg::PH_EXT;
            left_d  = LEN_BITS'(wfd_pkg::EXT16_BYTES);
          end else begin
            len_d = code_len;
            if (rx_byte_i[7]) begin
              phase_d = wfd_pkg::PH_KEY;
              left_d  = LEN_BITS'(wfd_pkg::KEY_BYTES);
            end else if (code_len == '0) begin
              push_o             = 1'b1;
              item_o.frame_end   = 1'b1;
              item_o.message_end = fin_q;
              if (fin_q) in_msg_d = 1'b0;
              phase_d = wfd_pkg::PH_HEADER;
              left_d  = '0;
            end else begin
              phase_d = wfd_pkg::PH_DATA;
              left_d  = code_len;
              pos_d   = 2'd0;
            end
          end
        end
        wfd_pkg::PH_EXT: begin
          len_d  = ext_len;
          left_d = left_dec;
          if (left_last) begin
            if (mask_q) begin
              phase_d = wfd_pkg::PH_KEY;
              left_d  = LEN_BITS'(wfd_pkg::KEY_BYTES);
            end else if (ext_len == '0) begin
              push_o             = 1'b1;
              item_o.frame_end   = 1'b1;
              item_o.message_end = fin_q;
              if (fin_q) in_msg_d = 1'b0;
              phase_d = wfd_pkg::PH_HEADER;
              left_d  = '0;
            end else begin
              phase_d = wfd_pkg::PH_DATA;
              left_d  = ext_len;
              pos_d   = 2'd0;
            end
          end
        end
        wfd_pkg::PH_KEY: begin
          key_d  = {key_q[23:0], rx_byte_i};
          left_d = left_dec;
          if (left_last) begin
            if (len_q == '0) begin
              push_o             = 1'b1;
              item_o.frame_end   = 1'b1;
              item_o.message_end = fin_q;
              if (fin_q) in_msg_d = 1'b0;
              phase_d = wfd_pkg::PH_HEADER;
              left_d  = '0;
            end else begin
              phase_d = wfd_pkg::PH_DATA;
              left_d  = len_q;
              pos_d   = 2'd0;
            end
          end
        end
        wfd_pkg::PH_DATA: begin
          push_o             = 1'b1;
          item_o.data_valid  = 1'b1;
          item_o.raw_byte    = rx_byte_i;
          item_o.key_byte    = mask_q ? key_sel : 8'h00;
          item_o.frame_end   = left_last;
          item_o.message_end = left_last & fin_q;
          if (mask_q) pos_d = pos_q + 2'd1;
          left_d = left_dec;
          if (left_last) begin
            if (fin_q) in_msg_d = 1'b0;
            phase_d = wfd_pkg::PH_HEADER;
            left_d  = '0;
          end
        end
        default: begin
          fin_d = rx_byte_i[7];
          if (!in_msg_q) begin
            opcode_d = rx_byte_i[3:0];
            in_msg_d = 1'b1;
          end
          phase_d = wfd_pkg::PH_LEN;
          left_d  = LEN_BITS'(1);
          len_d   = '0;
          mask_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wfd_pkg::PH_HEADER;
      left_q   <= '0;
      len_q    <= '0;
      key_q    <= '0;
      mask_q   <= 1'b0;
      pos_q    <= 2'd0;
      fin_q    <= 1'b0;
      opcode_q <= 4'd0;
      in_msg_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      len_q    <= len_d;
      key_q    <= key_d;
      mask_q   <= mask_d;
      pos_q    <= pos_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      in_msg_q <= in_msg_d;
    end
  end

endmodule

// ----- src/wfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_queue
// Short FIFO of result items between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wfd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  wfd_pkg::queue_item_t   item_i,
  input  logic                   pop_i,
  output wfd_pkg::queue_item_t   item_o,
  output wfd_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = $clog2(wfd_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(wfd_pkg::QUEUE_DEPTH + 1);

  wfd_pkg::queue_item_t entry_q [wfd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign item_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(wfd_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/wfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_back
// Output stage: unmasks queued payload bytes and holds the result item until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module wfd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wfd_pkg::queue_item_t   item_i,
  input  wfd_pkg::queue_status_t status_i,
  output logic                   pop_o,
  wfd_out_if.source              res_o
);

  logic       valid_q;
  logic       data_valid_q;
  logic [7:0] data_byte_q;
  logic [3:0] opcode_q;
  logic       frame_end_q;
  logic       message_end_q;

  assign pop_o = !status_i.empty && (!valid_q || res_o.ready);

  assign res_o.valid          = valid_q;
  assign res_o.data_valid     = data_valid_q;
  assign res_o.data_byte      = data_byte_q;
  assign res_o.message_opcode = opcode_q;
  assign res_o.frame_end      = frame_end_q;
  assign res_o.message_end    = message_end_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_valid_q  <= item_i.data_valid;
      data_byte_q   <= item_i.raw_byte ^ item_i.key_byte;
      opcode_q      <= item_i.message_opcode;
      frame_end_q   <= item_i.frame_end;
      message_end_q <= item_i.message_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ----- src/websocket_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Websocket frame parser: one received byte per item in, unmasked payload
// bytes and frame/message end marks out.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock, every cycle, as long as the result queue
// has room. Header, length and mask key bytes give no result; each payload
// byte gives one, and a zero-length frame gives a single end-only result on
// the byte that completes its header. A result reaches res_o through the
// queue, which captures it at the accepting edge, and the output register,
// which loads it once free. A two-item queue sits between the parser
// and the output register, so the input keeps running while a result waits
// to be taken. The length counter is LEN_BITS wide; longer extended lengths
// keep their low bits.
// ----------------------------------------------------------------------------
module websocket_frame_decoder #(
  parameter int unsigned LEN_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wfd_in_if.sink    rx_i,
  wfd_out_if.source res_o
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  wfd_pkg::queue_item_t   push_item;
  wfd_pkg::queue_item_t   head_item;
  wfd_pkg::queue_status_t status;

  assign rx_i.ready = !status.full;
  assign accept     = rx_i.valid && !status.full;

  wfd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .push_o    (push),
    .item_o    (push_item)
  );

  wfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (status)
  );

  wfd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (head_item),
    .status_i (status),
    .pop_o    (pop),
    .res_o    (res_o)
  );

endmodule

// ----- tb/sv/websocket_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder_tb
// Self-checking bench for the websocket frame decoder. A short table of
// directed bytes is followed by random frames. The random frames have all
// length encodings, masked and unmasked payloads, fragmented messages and
// zero-length frames. The bench model, or the table for some directed bytes,
// predicts each item, and every item taken from the result channel is compared field by field.
// Both sides stall in random bursts. The receiver also holds off once for a
// long stretch, so that the decoder fills up and stalls its input.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_tb;

  localparam int unsigned LEN_BITS     = 64;
  localparam logic [63:0] LEN_MASK     = {64{1'b1}} >> (64 - LEN_BITS);
  localparam int          DIR_N        = 28;
  localparam int          RAND_ITEMS   = 680;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [3:0] message_opcode;
    logic       frame_end;
    logic       message_end;
  } dec_res_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_GIVEN
  } chk_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    chk_e       chk;
    dec_res_t   res;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h81, CHK_NONE,  '0},
    '{8'h00, CHK_GIVEN, '{1'b0, 8'h00, 4'h1, 1'b1, 1'b1}},
    '{8'h02, CHK_NONE,  '0},
    '{8'h82, CHK_NONE,  '0},
    '{8'hFF, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'hA5, CHK_NONE,  '0},
    '{8'h5A, CHK_NONE,  '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'h80, CHK_NONE,  '0},
    '{8'h7E, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_GIVEN, '{1'b0, 8'h00, 4'h2, 1'b1, 1'b1}},
    '{8'h7F, CHK_NONE,  '0},
    '{8'hFF, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h00, CHK_NONE,  '0},
    '{8'h12, CHK_NONE,  '0},
    '{8'h34, CHK_NONE,  '0},
    '{8'h56, CHK_NONE,  '0},
    '{8'h78, CHK_GIVEN, '{1'b0, 8'h00, 4'hF, 1'b1, 1'b0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wfd_in_if  rx_if ();
  wfd_out_if res_if ();

  websocket_frame_decoder #(
    .LEN_BITS(LEN_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  dec_res_t    decoded_q[$];
  int          mismatches = 0;
  int          items_fed  = 0;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  int          hold_left  = 0;

  wfd_pkg::phase_e st_phase = wfd_pkg::PH_HEADER;
  logic [63:0] st_left    = '0;
  logic [63:0] st_len     = '0;
  logic [31:0] st_key     = '0;
  logic        st_masked  = 1'b0;
  logic [1:0]  st_keypos  = '0;
  logic        st_fin     = 1'b0;
  logic [3:0]  st_msg_op  = '0;
  logic        st_in_msg  = 1'b0;

  function automatic void close_frame();
    if (st_fin) st_in_msg = 1'b0;
    st_phase = wfd_pkg::PH_HEADER;
    st_left  = '0;
  endfunction

  function automatic bit start_payload(output dec_res_t r);
    r = '0;
    if (st_len == '0) begin
      r.message_opcode = st_msg_op;
      r.frame_end      = 1'b1;
      r.message_end    = st_fin;
      close_frame();
      return 1'b1;
    end
    st_phase  = wfd_pkg::PH_DATA;
    st_left   = st_len;
    st_keypos = '0;
    return 1'b0;
  endfunction

  function automatic bit end_of_header(output dec_res_t r);
    r = '0;
    if (st_masked) begin
      st_phase = wfd_pkg::PH_KEY;
      st_left  = 64'(wfd_pkg::KEY_BYTES);
      return 1'b0;
    end
    return start_payload(r);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output dec_res_t r);
    logic [7:0] key_b;
    r = '0;
    case (st_phase)
      wfd_pkg::PH_LEN: begin
        st_masked = b[7];
        st_len    = '0;
        if (b[6:0] == wfd_pkg::LEN_CODE_EXT64 || b[6:0] == wfd_pkg::LEN_CODE_EXT16) begin
          st_phase = wfd_pkg::PH_EXT;
          st_left  = (b[6:0] == wfd_pkg::LEN_CODE_EXT64) ? 64'(wfd_pkg::EXT64_BYTES)
                                                         : 64'(wfd_pkg::EXT16_BYTES);
          return 1'b0;
        end
        st_len = 64'(b[6:0]);
        return end_of_header(r);
      end
      wfd_pkg::PH_EXT: begin
        st_len = ((st_len << 8) | 64'(b)) & LEN_MASK;
        if (st_left != '0) st_left--;
        if (st_left != '0) return 1'b0;
        return end_of_header(r);
      end
      wfd_pkg::PH_KEY: begin
        st_key = {st_key[23:0], b};
        if (st_left != '0) st_left--;
        if (st_left != '0) return 1'b0;
        return start_payload(r);
      end
      wfd_pkg::PH_DATA: begin
        key_b = st_masked ? st_key[8*(3 - int'(st_keypos)) +: 8] : 8'h00;
        if (st_masked) st_keypos++;
        if (st_left != '0) st_left--;
        r.data_valid     = 1'b1;
        r.data_byte      = b ^ key_b;
        r.message_opcode = st_msg_op;
        if (st_left == '0) begin
          r.frame_end   = 1'b1;
          r.message_end = st_fin;
          close_frame();
        end
        return 1'b1;
      end
      default: begin
        st_fin = b[7];
        if (!st_in_msg) begin
          st_msg_op = b[3:0];
          st_in_msg = 1'b1;
        end
        st_phase  = wfd_pkg::PH_LEN;
        st_left   = 64'd1;
        st_len    = '0;
        st_masked = 1'b0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] b, input chk_e chk = CHK_MODEL,
                           input dec_res_t given = '0);
    dec_res_t r;
    bit       got;
    got = decode_byte(b, r);
    if (chk == CHK_GIVEN) decoded_q.push_back(given);
    else if (chk == CHK_MODEL && got) decoded_q.push_back(r);
    if (!calm && !hold_req && hold_left == 0 && $urandom_range(0, 9) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    items_fed++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input bit masked, input int kind,
                            input logic [63:0] len, input int n_pay);
    logic [31:0] key;
    key = $urandom;
    send_byte(hdr);
    case (kind)
      0: send_byte({masked, len[6:0]});
      1: begin
        send_byte({masked, wfd_pkg::LEN_CODE_EXT16});
        for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: begin
        send_byte({masked, wfd_pkg::LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int i = 0; i < n_pay; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic take_result();
    dec_res_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("item arrived with nothing expected");
      return;
    end
    want = decoded_q.pop_front();
    if (res_if.data_valid !== want.data_valid)
      report_mismatch($sformatf("data_valid %b, expected %b",
                                res_if.data_valid, want.data_valid));
    if (res_if.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %h, expected %h",
                                res_if.data_byte, want.data_byte));
    if (res_if.message_opcode !== want.message_opcode)
      report_mismatch($sformatf("message_opcode %h, expected %h",
                                res_if.message_opcode, want.message_opcode));
    if (res_if.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b, expected %b",
                                res_if.frame_end, want.frame_end));
    if (res_if.message_end !== want.message_end)
      report_mismatch($sformatf("message_end %b, expected %b",
                                res_if.message_end, want.message_end));
  endtask

  int stall_left = 0;

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) take_result();
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0]  hdr;
    logic [63:0] len;
    bit          masked;
    bit          pressed;
    int          pick;
    int          kind;
    int          spin;
    pressed = 1'b0;
    spin    = 0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i]) send_byte(DIR_TAB[i].rx_byte, DIR_TAB[i].chk, DIR_TAB[i].res);

    while (items_fed < DIR_N + RAND_ITEMS) begin
      if (items_fed >= DIR_N + RAND_ITEMS - 100) calm = 1'b1;
      hdr = {($urandom_range(0, 3) != 0), 3'($urandom_range(0, 7)),
             4'($urandom_range(0, 15))};
      masked = 1'($urandom_range(0, 1));
      if (!pressed && items_fed >= 300) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        send_frame(hdr, masked, 0, 64'd100, 100);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          kind = 0;
          if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? 64'd0 : 64'd125;
          else len = 64'($urandom_range(1, 16));
        end else begin
          kind = (pick < 8) ? 1 : 2;
          if ($urandom_range(0, 3) == 0) len = 64'($urandom_range(126, 300));
          else len = 64'($urandom_range(0, 40));
        end
        send_frame(hdr, masked, kind, len, int'(len));
      end
    end

    // leave a frame open whose 64-bit length has a high bit set
    hdr = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))};
    len = {$urandom, $urandom};
    len[62] = 1'b1;
    send_frame(hdr, 1'($urandom_range(0, 1)), 2, len, 24);
    rx_if.valid <= 1'b0;

    while (decoded_q.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived", decoded_q.size()));

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wfd_pkg.sv
src/wfd_in_if.sv
src/wfd_out_if.sv
src/wfd_front.sv
src/wfd_queue.sv
src/wfd_back.sv
src/websocket_frame_decoder.sv
tb/sv/websocket_frame_decoder_tb.sv
